[hw/rtl/assert_macros.svh]
// Assertion macros used by the top level of the page table map.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every rising clock edge outside reset.
`define TLPT_ASSERT(name, prop, clk, rst_n) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Condition must never be true outside reset.
`define TLPT_ASSERT_NEVER(name, cond, clk, rst_n) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`else

`define TLPT_ASSERT(name, prop, clk, rst_n)
`define TLPT_ASSERT_NEVER(name, cond, clk, rst_n)

`endif

`endif

[hw/rtl/tlpt_pkg.sv]
// Package: constants and types of the two-level page table map.
`default_nettype none

package tlpt_pkg;

  localparam int unsigned DirEntries   = 1024;
  localparam int unsigned TableEntries = 1024;
  localparam int unsigned DirIdxW      = 10;
  localparam int unsigned TblIdxW      = 10;
  localparam int unsigned OffsW        = 12;
  localparam int unsigned FrameW       = 20;
  localparam int unsigned FlagsW       = 12;
  localparam int unsigned AddrW        = 32;
  localparam int unsigned DefTablePool = 16;

  // flag bit positions, both levels
  localparam int unsigned FlagPresent  = 0;
  localparam int unsigned FlagWritable = 1;
  localparam int unsigned FlagUser     = 2;
  localparam int unsigned DirFlagsW    = 3;

  typedef enum logic [1:0] {
    OP_MAP       = 2'd0,
    OP_UNMAP     = 2'd1,
    OP_TRANSLATE = 2'd2
  } op_e;

  localparam logic RespOk        = 1'b0;
  localparam logic RespPoolEmpty = 1'b1;

endpackage

`default_nettype wire

[hw/rtl/two_level_page_table_map_top.sv]
// Top level: two-level page table (directory plus table pool) in two RAMs.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------------
//  in      | request   | in_valid_i/in_ready_o | operation, virt_addr, phys_addr, flags
//  out     | response  | out_valid_o/out_ready_i | phys_out, mapped, status
//
// Map, unmap, the unused code and a translate whose directory entry is absent
// go through a directory read, then a directory and table write or the
// result; a translate through a present directory entry goes through a
// directory read, a table read and the result. The dependent read through the
// directory RAM into the table RAM sets this order.
// After reset a clearing pass zeroes both RAMs, one entry per cycle over all
// TablePool*1024 table entries; in_ready_o stays low until it is done.
// A response that is not taken parks in the output register; the next request
// is still accepted and its result waits in a hold register if needed.
`default_nettype none
`include "assert_macros.svh"

module two_level_page_table_map_top
  import tlpt_pkg::*;
#(
  parameter int unsigned TablePool = DefTablePool
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [31:0] virt_addr_i,
  input  logic [31:0] phys_addr_i,
  input  logic [11:0] entry_flags_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] phys_out_o,
  output logic        mapped_o,
  output logic        status_o
);

  // Pool index width, allocation counter width, table RAM geometry.
  localparam int unsigned PoolW    = (TablePool > 1) ? $clog2(TablePool) : 1;
  localparam int unsigned NftW     = $clog2(TablePool + 1);
  localparam int unsigned TblDepth = TablePool * TableEntries;
  localparam int unsigned TblAw    = $clog2(TblDepth);
  localparam int unsigned DirW     = PoolW + DirFlagsW;

  typedef enum logic [2:0] {
    S_CLEAR,  // zeroing sweep after reset
    S_IDLE,   // waiting for a request
    S_DIR,    // directory entry available
    S_TBL,    // table entry available (translate)
    S_WAIT    // result held, output register busy
  } state_e;

  state_e state_q, state_d;

  logic [TblAw-1:0] clr_q, clr_d;
  logic [NftW-1:0]  nft_q, nft_d;

  logic        out_valid_q, out_valid_d;
  logic [31:0] out_phys_q, out_phys_d;
  logic        out_mapped_q, out_mapped_d;
  logic        out_status_q, out_status_d;

  // hold register for a result that could not enter the output stage
  logic [31:0] hold_phys_q, hold_phys_d;
  logic        hold_mapped_q, hold_mapped_d;
  logic        hold_status_q, hold_status_d;

  // latched request
  op_e                op_q;
  logic [DirIdxW-1:0] dir_idx_q;
  logic [TblIdxW-1:0] tbl_idx_q;
  logic [OffsW-1:0]   offs_q;
  logic [FrameW-1:0]  frame_q;
  logic [FlagsW-1:0]  flags_q;

  // RAM ports
  logic               dir_we;
  logic [DirIdxW-1:0] dir_addr;
  logic [DirW-1:0]    dir_wdata, dir_rdata;
  logic               tbl_we;
  logic [TblAw-1:0]   tbl_addr;
  logic [31:0]        tbl_wdata, tbl_rdata;

  logic in_fire, out_free, dir_present, pool_empty;
  logic [PoolW-1:0] dent_pool, new_pool;

  // result of the current step
  logic [31:0] res_phys;
  logic        res_mapped, res_status, res_done;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign dir_present = dir_rdata[FlagPresent];
  assign dent_pool   = dir_rdata[DirW-1:DirFlagsW];
  assign new_pool    = nft_q[PoolW-1:0];
  assign pool_empty  = (nft_q == NftW'(TablePool));

  tlpt_ram #(
    .Width(DirW),
    .Depth(DirEntries)
  ) u_dir_ram (
    .clk_i  (clk_i),
    .we_i   (dir_we),
    .addr_i (dir_addr),
    .wdata_i(dir_wdata),
    .rdata_o(dir_rdata)
  );

  tlpt_ram #(
    .Width(32),
    .Depth(TblDepth)
  ) u_tbl_ram (
    .clk_i  (clk_i),
    .we_i   (tbl_we),
    .addr_i (tbl_addr),
    .wdata_i(tbl_wdata),
    .rdata_o(tbl_rdata)
  );

  always_comb begin
    state_d       = state_q;
    clr_d         = clr_q;
    nft_d         = nft_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    out_phys_d    = out_phys_q;
    out_mapped_d  = out_mapped_q;
    out_status_d  = out_status_q;
    hold_phys_d   = hold_phys_q;
    hold_mapped_d = hold_mapped_q;
    hold_status_d = hold_status_q;

    dir_we    = 1'b0;
    dir_addr  = virt_addr_i[31:22];
    dir_wdata = '0;
    tbl_we    = 1'b0;
    tbl_addr  = TblAw'({dent_pool, tbl_idx_q});
    tbl_wdata = '0;

    res_phys   = '0;
    res_mapped = 1'b0;
    res_status = RespOk;
    res_done   = 1'b0;

    case (state_q)
      S_CLEAR: begin
        dir_we   = ({1'b0, clr_q} < (TblAw + 1)'(DirEntries));
        dir_addr = clr_q[DirIdxW-1:0];
        tbl_we   = 1'b1;
        tbl_addr = clr_q;
        clr_d    = clr_q + TblAw'(1);
        if (clr_q == TblAw'(TblDepth - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_DIR;
        end
      end
      S_DIR: begin
        dir_addr = dir_idx_q;
        res_done = 1'b1;
        case (op_q)
          OP_MAP: begin
            if (!dir_present) begin
              if (pool_empty) begin
                res_status = RespPoolEmpty;
              end else begin
                // take a fresh table from the pool
                dir_we    = 1'b1;
                dir_wdata = {new_pool, flags_q[FlagUser], 1'b1, 1'b1};
                nft_d     = nft_q + NftW'(1);
                tbl_we    = 1'b1;
                tbl_addr  = TblAw'({new_pool, tbl_idx_q});
                tbl_wdata = {frame_q, flags_q};
              end
            end else begin
              // user bit is sticky at the directory level
              dir_we    = flags_q[FlagUser];
              dir_wdata = dir_rdata | DirW'(1 << FlagUser);
              tbl_we    = 1'b1;
              tbl_wdata = {frame_q, flags_q};
            end
          end
          OP_UNMAP: begin
            tbl_we = dir_present;
          end
          OP_TRANSLATE: begin
            if (dir_present) begin
              res_done = 1'b0;
              state_d  = S_TBL;
            end
          end
          default: begin
          end
        endcase
      end
      S_TBL: begin
        res_done = 1'b1;
        if (tbl_rdata[FlagPresent]) begin
          res_phys   = {tbl_rdata[31:OffsW], offs_q};
          res_mapped = 1'b1;
        end
      end
      S_WAIT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_phys_d   = hold_phys_q;
          out_mapped_d = hold_mapped_q;
          out_status_d = hold_status_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (res_done) begin
      if (out_free) begin
        out_valid_d  = 1'b1;
        out_phys_d   = res_phys;
        out_mapped_d = res_mapped;
        out_status_d = res_status;
        state_d      = S_IDLE;
      end else begin
        hold_phys_d   = res_phys;
        hold_mapped_d = res_mapped;
        hold_status_d = res_status;
        state_d       = S_WAIT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_CLEAR;
      clr_q         <= '0;
      nft_q         <= '0;
      out_valid_q   <= 1'b0;
      out_phys_q    <= '0;
      out_mapped_q  <= 1'b0;
      out_status_q  <= RespOk;
      hold_phys_q   <= '0;
      hold_mapped_q <= 1'b0;
      hold_status_q <= RespOk;
    end else begin
      state_q       <= state_d;
      clr_q         <= clr_d;
      nft_q         <= nft_d;
      out_valid_q   <= out_valid_d;
      out_phys_q    <= out_phys_d;
      out_mapped_q  <= out_mapped_d;
      out_status_q  <= out_status_d;
      hold_phys_q   <= hold_phys_d;
      hold_mapped_q <= hold_mapped_d;
      hold_status_q <= hold_status_d;
    end
  end

  // request capture, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q      <= op_e'(operation_i);
      dir_idx_q <= virt_addr_i[31:22];
      tbl_idx_q <= virt_addr_i[21:12];
      offs_q    <= virt_addr_i[OffsW-1:0];
      frame_q   <= phys_addr_i[31:OffsW];
      flags_q   <= entry_flags_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign phys_out_o  = out_phys_q;
  assign mapped_o    = out_mapped_q;
  assign status_o    = out_status_q;

  // allocation counter never passes the pool size
  `TLPT_ASSERT(a_nft_bound, nft_q <= NftW'(TablePool), clk_i, rst_ni)
  // an accepted request always reaches the directory step next
  `TLPT_ASSERT(a_fire_to_dir, in_fire |=> (state_q == S_DIR), clk_i, rst_ni)
  // a hit and a pool failure never come together
  `TLPT_ASSERT_NEVER(a_hit_and_fail, out_valid_q && out_mapped_q && out_status_q, clk_i, rst_ni)
  // taking a table from the pool bumps the counter by exactly one
  `TLPT_ASSERT(a_alloc_count,
    (state_q == S_DIR && op_q == OP_MAP && !dir_present && !pool_empty) |=>
      (nft_q == $past(nft_q) + NftW'(1)), clk_i, rst_ni)

endmodule

`default_nettype wire

[hw/rtl/tlpt_ram.sv]
// Generic single-port synchronous RAM with registered read.
`default_nettype none

module tlpt_ram #(
  parameter  int unsigned Width = 8,
  parameter  int unsigned Depth = 16,
  localparam int unsigned Aw    = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[tb/testbench.sv]
// Testbench for the two-level page table map: directed and random requests, scoreboard check.
`timescale 1ns / 1ps

module testbench;
  import tlpt_pkg::*;

  localparam int unsigned PoolIdxW   = $clog2(DefTablePool);
  localparam int unsigned DirEntW    = DirFlagsW + PoolIdxW;
  localparam logic [1:0]  OpReserved = 2'd3;   // unused operation code
  localparam int unsigned DrainLimit = 20000;  // cycles allowed for the last responses

  // expected response of one request
  typedef struct packed {
    logic [AddrW-1:0] phys;
    logic             mapped;
    logic             status;
  } page_op_result_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [1:0]        operation_i;
  logic [AddrW-1:0]  virt_addr_i;
  logic [AddrW-1:0]  phys_addr_i;
  logic [FlagsW-1:0] entry_flags_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [AddrW-1:0]  phys_out_o;
  logic              mapped_o;
  logic              status_o;

  two_level_page_table_map_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .operation_i   (operation_i),
    .virt_addr_i   (virt_addr_i),
    .phys_addr_i   (phys_addr_i),
    .entry_flags_i (entry_flags_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .phys_out_o    (phys_out_o),
    .mapped_o      (mapped_o),
    .status_o      (status_o)
  );

  // Shadow copy of the block's state. Directory entry: bits 2:0 flags,
  // upper bits the pool index of its table. Table store is indexed by
  // {pool index, table index}.
  logic [DirEntW-1:0] dir_shadow [DirEntries];
  logic [AddrW-1:0]   tbl_shadow [DefTablePool*TableEntries];
  int unsigned        tables_taken;

  page_op_result_t    due_results[$];   // responses still owed by the block, oldest first
  logic [DirIdxW-1:0] taken_dirs[$];    // directory slots that own a table
  logic [AddrW-1:0]   recent_maps[$];   // virtual pages mapped lately, for hits

  int unsigned mismatches;
  int unsigned sender_idle_pct;
  int unsigned recv_stall_pct;

  // 8 ns clock
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Receiver: ready decided once per falling edge.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic report_mismatch(input string what, input logic [AddrW-1:0] got,
                                 input logic [AddrW-1:0] want);
    mismatches++;
    $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
  endtask

  // Walk the shadow tables for one accepted request, update them and queue the
  // response the block owes.
  task automatic compute_page_op(input logic [1:0] op, input logic [AddrW-1:0] va,
                                 input logic [AddrW-1:0] pa, input logic [FlagsW-1:0] fl);
    logic [DirIdxW-1:0]  d_idx;
    logic [TblIdxW-1:0]  t_idx;
    logic [DirEntW-1:0]  dent;
    logic [PoolIdxW-1:0] tnum;
    logic [AddrW-1:0]    pte;
    int unsigned         slot;
    bit                  ok;
    page_op_result_t     res;
    d_idx = va[AddrW-1 -: DirIdxW];
    t_idx = va[OffsW +: TblIdxW];
    dent  = dir_shadow[d_idx];
    res   = '0;
    ok    = 1'b1;
    if (op == OP_MAP) begin
      if (!dent[FlagPresent]) begin
        if (tables_taken >= DefTablePool) begin
          // pool exhausted: nothing changes
          ok         = 1'b0;
          res.status = RespPoolEmpty;
        end else begin
          tnum                          = tables_taken[PoolIdxW-1:0];
          dent                          = '0;
          dent[DirEntW-1:DirFlagsW]     = tnum;
          dent[FlagPresent]             = 1'b1;
          dent[FlagWritable]            = 1'b1;
          dent[FlagUser]                = fl[FlagUser];
          dir_shadow[d_idx]             = dent;
          tables_taken++;
          taken_dirs.push_back(d_idx);
        end
      end else if (fl[FlagUser]) begin
        // user bit is sticky on the directory level
        dent[FlagUser]    = 1'b1;
        dir_shadow[d_idx] = dent;
      end
      if (ok) begin
        slot             = dent[DirEntW-1:DirFlagsW] * TableEntries + t_idx;
        tbl_shadow[slot] = {pa[AddrW-1:OffsW], fl};
      end
    end else if (op == OP_UNMAP) begin
      if (dent[FlagPresent]) begin
        slot             = dent[DirEntW-1:DirFlagsW] * TableEntries + t_idx;
        tbl_shadow[slot] = '0;
      end
    end else if (op == OP_TRANSLATE) begin
      if (dent[FlagPresent]) begin
        slot = dent[DirEntW-1:DirFlagsW] * TableEntries + t_idx;
        pte  = tbl_shadow[slot];
        if (pte[FlagPresent]) begin
          res.phys   = {pte[AddrW-1:OffsW], va[OffsW-1:0]};
          res.mapped = 1'b1;
        end
      end
    end
    due_results.push_back(res);
  endtask

  // Present one request, with a random lead-in gap; valid stays up after
  // acceptance so back-to-back requests need no extra edge.
  task automatic issue_request(input logic [1:0] op, input logic [AddrW-1:0] va,
                               input logic [AddrW-1:0] pa, input logic [FlagsW-1:0] fl);
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    operation_i   <= op;
    virt_addr_i   <= va;
    phys_addr_i   <= pa;
    entry_flags_i <= fl;
    do @(posedge clk_i); while (!in_ready_o);
    compute_page_op(op, va, pa, fl);
  endtask

  // Response check: every accepted response against the oldest expectation.
  always @(posedge clk_i) begin
    page_op_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (due_results.size() == 0) begin
        report_mismatch("response with no request pending", phys_out_o, '0);
      end else begin
        want = due_results.pop_front();
        if (phys_out_o !== want.phys) report_mismatch("phys_out", phys_out_o, want.phys);
        if (mapped_o !== want.mapped) begin
          report_mismatch("mapped", AddrW'(mapped_o), AddrW'(want.mapped));
        end
        if (status_o !== want.status) begin
          report_mismatch("status", AddrW'(status_o), AddrW'(want.status));
        end
      end
    end
  end

  // Extremes of every field and each special case but pool exhaustion, from an empty pool.
  task automatic test_basic_ops();
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    issue_request(OP_TRANSLATE, 32'h0000_0000, 32'h0, 12'h000);  // empty directory
    issue_request(OP_UNMAP, 32'hFFFF_FFFF, 32'h0, 12'h000);      // unmap of absent dir
    issue_request(OP_MAP, 32'h0000_0000, 32'hFFFF_FFFF, 12'h003); // takes table, no user
    issue_request(OP_TRANSLATE, 32'h0000_0FFF, 32'h0, 12'h000);
    issue_request(OP_MAP, 32'hFFFF_F000, 32'h1234_5ABC, 12'hFFF); // top slot, all flags
    issue_request(OP_TRANSLATE, 32'hFFFF_FFFF, 32'h0, 12'h000);
    issue_request(OP_MAP, 32'h0000_1000, 32'hFFFF_FFFF, 12'h004); // user, not present
    issue_request(OP_TRANSLATE, 32'h0000_1234, 32'h0, 12'h000);
    issue_request(OP_MAP, 32'h0000_1000, 32'h0000_0000, 12'h001); // frame zero
    issue_request(OP_TRANSLATE, 32'h0000_1ABC, 32'h0, 12'h000);
    issue_request(OP_UNMAP, 32'h0000_1000, 32'h0, 12'h000);
    issue_request(OP_TRANSLATE, 32'h0000_1000, 32'h0, 12'h000);
    issue_request(OpReserved, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF); // no effect
    issue_request(OP_TRANSLATE, 32'h0000_0000, 32'h0, 12'h000);
  endtask

  // Fill the pool, then hit the exhausted case.
  task automatic test_pool_exhaustion();
    logic [DirIdxW-1:0] d;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    d = 10'h101;
    while (tables_taken < DefTablePool) begin
      issue_request(OP_MAP, {d, 10'h155, 12'h000}, $urandom(), 12'h003);
      d++;
    end
    issue_request(OP_MAP, {10'h2AA, 10'h0AA, 12'h000}, 32'hAAAA_A000, 12'h007);
    issue_request(OP_TRANSLATE, {10'h2AA, 10'h0AA, 12'h555}, 32'h0, 12'h000);
    issue_request(OP_UNMAP, {10'h2AA, 10'h0AA, 12'h000}, 32'h0, 12'h000);
    // existing directory entries still map fine
    issue_request(OP_MAP, {10'h000, 10'h002, 12'h000}, 32'h5555_5000, 12'h005);
  endtask

  // Mostly pages in directories that own tables, so translates hit.
  task automatic test_random_traffic(input int unsigned count, input int unsigned idle_pct,
                                     input int unsigned stall_pct);
    int unsigned        r;
    logic [1:0]         op;
    logic [AddrW-1:0]   va;
    logic [AddrW-1:0]   pa;
    logic [FlagsW-1:0]  fl;
    logic [DirIdxW-1:0] d;
    logic [TblIdxW-1:0] t;
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < 35)      op = OP_MAP;
      else if (r < 50) op = OP_UNMAP;
      else if (r < 95) op = OP_TRANSLATE;
      else             op = OpReserved;
      if (op != OP_MAP && recent_maps.size() != 0 && $urandom_range(99) < 60) begin
        va             = recent_maps[$urandom_range(recent_maps.size() - 1)];
        va[OffsW-1:0]  = OffsW'($urandom_range(4095));
      end else begin
        if ($urandom_range(99) < 80) d = taken_dirs[$urandom_range(taken_dirs.size() - 1)];
        else                         d = DirIdxW'($urandom_range(DirEntries - 1));
        if ($urandom_range(99) < 75) t = TblIdxW'($urandom_range(31));
        else                         t = TblIdxW'($urandom_range(TableEntries - 1));
        va = {d, t, 12'(($urandom_range(4095)))};
      end
      pa = $urandom();
      fl = FlagsW'($urandom_range(4095));
      if ($urandom_range(99) < 75) fl[FlagPresent] = 1'b1;
      if (op == OP_MAP) begin
        recent_maps.push_back(va);
        if (recent_maps.size() > 64) void'(recent_maps.pop_front());
      end
      issue_request(op, va, pa, fl);
    end
  endtask

  // Hard stop well beyond the slowest legal run (clearing pass included).
  initial begin
    #4000000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int unsigned waited;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    out_ready_i     = 1'b0;
    operation_i     = '0;
    virt_addr_i     = '0;
    phys_addr_i     = '0;
    entry_flags_i   = '0;
    mismatches      = 0;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    tables_taken    = 0;
    for (int i = 0; i < DirEntries; i++) dir_shadow[i] = '0;
    for (int i = 0; i < DefTablePool*TableEntries; i++) tbl_shadow[i] = '0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_basic_ops();
    test_pool_exhaustion();
    test_random_traffic(380, 0, 0);
    test_random_traffic(380, 49, 0);
    test_random_traffic(380, 0, 49);
    test_random_traffic(380, 29, 29);

    // drain: stop sending, take every response still owed
    @(negedge clk_i);
    in_valid_i     <= 1'b0;
    recv_stall_pct  = 0;
    waited          = 0;
    while (due_results.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (20) @(posedge clk_i);
    if (due_results.size() != 0) begin
      report_mismatch("responses never delivered", AddrW'(due_results.size()), '0);
    end
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
